FILE: src/ccsri_pkg.sv
// ccsri_pkg: shared types, constants and codes for the regularised inverse block.
// No dependencies; every other file in src imports it.
package ccsri_pkg;

    // Parameter defaults
    localparam int MAX_DIM_DEF   = 1024;
    localparam int FRAC_BITS_DEF = 16;

    // Fixed field widths
    localparam int VAL_W     = 32;
    localparam int POS_W     = 10;
    localparam int DIM_W     = 11;
    localparam int CFG_IDX_W = 2;
    localparam int SQ_W      = 64;

    // Register reset values
    localparam logic [VAL_W-1:0] GAMMA_RST = 32'd655;
    localparam logic [DIM_W-1:0] DIM_RST   = 11'd1024;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GAMMA  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

    // Saturation limits of a quotient magnitude
    localparam logic [VAL_W-1:0] POS_LIMIT = 32'h7FFF_FFFF;
    localparam logic [VAL_W-1:0] NEG_LIMIT = 32'h8000_0000;

    // What an input beat does
    typedef enum logic [1:0] {
        KIND_HOLD,
        KIND_SINGLE,
        KIND_PAIR
    } item_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ1,
        ST_SQ2,
        ST_SUM,
        ST_DIV,
        ST_LOAD
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic mul_en;
        logic mul_sel;
        logic sum_init;
        logic sum_add;
        logic div_init;
        logic div_step;
        logic load;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        item_kind_t kind;
        logic       div_last;
        logic       buf_busy;
    } stat_t;

    // One result beat
    typedef struct packed {
        logic [POS_W-1:0]        row;
        logic [POS_W-1:0]        col;
        logic signed [VAL_W-1:0] value;
        logic                    sat;
        logic                    last;
        logic                    eof;
    } res_t;

endpackage

FILE: src/ccsri_div.sv
// ccsri_div: restoring divider, one quotient bit per cycle while step is high, signed and saturated result.
// Depends on ccsri_pkg.
module ccsri_div (
    input  logic                           clk,
    input  logic                           init,
    input  logic                           step,
    input  logic [ccsri_pkg::VAL_W-1:0]    mag,
    input  logic                           neg,
    input  logic [ccsri_pkg::SQ_W-1:0]     divisor,
    output logic signed [ccsri_pkg::VAL_W-1:0] value,
    output logic                           sat
);
    import ccsri_pkg::*;

    logic [SQ_W-1:0]  rem_reg;
    logic [VAL_W-1:0] dvd_reg;
    logic [VAL_W-1:0] quo_reg;
    logic             ovf_reg;
    logic             neg_reg;

    logic [SQ_W:0]    rem_ext;
    logic             ge;
    logic [SQ_W-1:0]  rem_next;
    logic [VAL_W-1:0] limit;
    logic             over;
    logic             zero_div;
    logic [VAL_W-1:0] mag_q;

    // Trial subtract; remainder stays below the divisor so 64 bits hold it
    always_comb
    begin
        rem_ext  = {rem_reg, dvd_reg[VAL_W-1]};
        ge       = (rem_ext >= {1'b0, divisor});
        rem_next = ge ? SQ_W'(rem_ext - {1'b0, divisor}) : rem_ext[SQ_W-1:0];
    end

    // Iteration registers; dividend bits shift out MSB first, then zeros
    always_ff @(posedge clk)
    begin
        if (init)
        begin
            rem_reg <= '0;
            dvd_reg <= mag;
            quo_reg <= '0;
            ovf_reg <= 1'b0;
            neg_reg <= neg;
        end
        else if (step)
        begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[VAL_W-2:0], 1'b0};
            quo_reg <= {quo_reg[VAL_W-2:0], ge};
            ovf_reg <= ovf_reg | quo_reg[VAL_W-1];
        end
    end

    // Clip, sign, and force zero on a zero divisor
    always_comb
    begin
        limit    = neg_reg ? NEG_LIMIT : POS_LIMIT;
        over     = ovf_reg || (quo_reg > limit);
        zero_div = (divisor == '0);
        mag_q    = over ? limit : quo_reg;
        if (zero_div)
            value = '0;
        else
            value = neg_reg ? -mag_q : mag_q;
        sat = !zero_div && over;
    end

endmodule

FILE: src/ccsri_dp.sv
// ccsri_dp: counters, held pair halves, squarer, two dividers and the result buffer.
// Depends on ccsri_pkg and ccsri_div.
module ccsri_dp #(
    parameter int MAX_DIM   = ccsri_pkg::MAX_DIM_DEF,
    parameter int FRAC_BITS = ccsri_pkg::FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  ccsri_pkg::cmd_t                    cmd,
    output ccsri_pkg::stat_t                   stat,
    input  logic [ccsri_pkg::VAL_W-1:0]        spectrum_value,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ccsri_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ccsri_pkg::VAL_W-1:0]        cfg_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [ccsri_pkg::POS_W-1:0]        row_index,
    output logic [ccsri_pkg::POS_W-1:0]        column_index,
    output logic signed [ccsri_pkg::VAL_W-1:0] result_value,
    output logic                               saturated,
    output logic                               last_of_run,
    output logic                               end_of_frame
);
    import ccsri_pkg::*;

    localparam int CNT_W  = $clog2(MAX_DIM);
    localparam int DW     = $clog2(MAX_DIM + 1);
    localparam int N_ITER = VAL_W + 2 * FRAC_BITS;
    localparam int IT_W   = $clog2(N_ITER);

    function automatic logic [DW-1:0] clamp_dim(input logic [DIM_W-1:0] raw);
        logic [DW-1:0] res;
        if (raw < DIM_W'(2))
            res = DW'(2);
        else if (32'(raw) > 32'(MAX_DIM))
            res = DW'(MAX_DIM);
        else
            res = DW'(raw);
        return res;
    endfunction

    function automatic logic [VAL_W-1:0] magn(input logic [VAL_W-1:0] a);
        return a[VAL_W-1] ? -a : a;
    endfunction

    // Configuration and position
    logic [VAL_W-1:0] gamma_reg;
    logic [DW-1:0]    w_reg;
    logic [DW-1:0]    h_reg;
    logic [CNT_W-1:0] row_reg;
    logic [CNT_W-1:0] col_reg;

    // First halves waiting for partners
    logic [VAL_W-1:0] held_int_reg;
    logic [VAL_W-1:0] held_first_reg;
    logic [VAL_W-1:0] held_last_reg;

    // Operands and tags captured on accept
    logic [VAL_W-1:0] mag1_reg;
    logic [VAL_W-1:0] mag2_reg;
    logic             neg1_reg;
    logic             neg2_reg;
    logic             pair_reg;
    logic [POS_W-1:0] r0_reg;
    logic [POS_W-1:0] c0_reg;
    logic [POS_W-1:0] r1_reg;
    logic [POS_W-1:0] c1_reg;
    logic             eof_reg;

    // Arithmetic
    logic [SQ_W-1:0]  prod_reg;
    logic [SQ_W-1:0]  sum_reg;
    logic [IT_W-1:0]  it_reg;

    // Result buffer
    res_t             slot0_reg;
    res_t             slot1_reg;
    logic [1:0]       cnt_reg;

    logic             last_c;
    logic             last_r;
    logic             vertical;
    logic             edge_row;
    item_kind_t       kind;
    logic [VAL_W-1:0] held_sel;
    logic [VAL_W-1:0] first_a;
    logic [VAL_W-1:0] mul_op;
    logic [SQ_W-1:0]  g_shift;
    logic signed [VAL_W-1:0] val_a;
    logic signed [VAL_W-1:0] val_b;
    logic             sat_a;
    logic             sat_b;
    logic             pop;
    logic             cfg_we;

    // Classify the next beat from its raster position
    always_comb
    begin
        last_c   = (DW'(col_reg) == w_reg - DW'(1));
        last_r   = (DW'(row_reg) == h_reg - DW'(1));
        vertical = (col_reg == '0) || (!w_reg[0] && last_c);
        edge_row = (row_reg == '0) || (!h_reg[0] && last_r);
        if (vertical)
        begin
            if (edge_row)
                kind = KIND_SINGLE;
            else if (row_reg[0])
                kind = KIND_HOLD;
            else
                kind = KIND_PAIR;
        end
        else
            kind = col_reg[0] ? KIND_HOLD : KIND_PAIR;
        if (vertical)
            held_sel = (col_reg != '0) ? held_last_reg : held_first_reg;
        else
            held_sel = held_int_reg;
        first_a = (kind == KIND_SINGLE) ? spectrum_value : held_sel;
    end

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    // Registers, frame position and held halves
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gamma_reg      <= GAMMA_RST;
            w_reg          <= clamp_dim(DIM_RST);
            h_reg          <= clamp_dim(DIM_RST);
            row_reg        <= '0;
            col_reg        <= '0;
            held_int_reg   <= '0;
            held_first_reg <= '0;
            held_last_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_GAMMA:
                    gamma_reg <= cfg_data;
                CFG_WIDTH:
                begin
                    w_reg   <= clamp_dim(cfg_data[DIM_W-1:0]);
                    row_reg <= '0;
                    col_reg <= '0;
                end
                CFG_HEIGHT:
                begin
                    h_reg   <= clamp_dim(cfg_data[DIM_W-1:0]);
                    row_reg <= '0;
                    col_reg <= '0;
                end
                default:
                    ;
            endcase
        end
        else if (cmd.accept)
        begin
            if (kind == KIND_HOLD)
            begin
                if (!vertical)
                    held_int_reg <= spectrum_value;
                else if (col_reg != '0)
                    held_last_reg <= spectrum_value;
                else
                    held_first_reg <= spectrum_value;
            end
            if (last_c)
            begin
                col_reg <= '0;
                row_reg <= last_r ? '0 : row_reg + CNT_W'(1);
            end
            else
                col_reg <= col_reg + CNT_W'(1);
        end
    end

    // Operand and tag capture
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            mag1_reg <= magn(first_a);
            neg1_reg <= first_a[VAL_W-1];
            mag2_reg <= (kind == KIND_PAIR) ? magn(spectrum_value) : '0;
            neg2_reg <= !spectrum_value[VAL_W-1];
            pair_reg <= (kind == KIND_PAIR);
            eof_reg  <= last_r && last_c;
            r1_reg   <= POS_W'(row_reg);
            c1_reg   <= POS_W'(col_reg);
            if (kind == KIND_PAIR && vertical)
            begin
                r0_reg <= POS_W'(row_reg - CNT_W'(1));
                c0_reg <= POS_W'(col_reg);
            end
            else if (kind == KIND_PAIR)
            begin
                r0_reg <= POS_W'(row_reg);
                c0_reg <= POS_W'(col_reg - CNT_W'(1));
            end
            else
            begin
                r0_reg <= POS_W'(row_reg);
                c0_reg <= POS_W'(col_reg);
            end
        end
    end

    // Squarer and divisor accumulation
    assign mul_op  = cmd.mul_sel ? mag2_reg : mag1_reg;
    assign g_shift = SQ_W'(gamma_reg) << FRAC_BITS;

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
            prod_reg <= SQ_W'(mul_op) * SQ_W'(mul_op);
        if (cmd.sum_init)
            sum_reg <= prod_reg + g_shift;
        else if (cmd.sum_add)
            sum_reg <= sum_reg + prod_reg;
    end

    // Quotient bit count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            it_reg <= '0;
        else if (cmd.div_init)
            it_reg <= IT_W'(N_ITER - 1);
        else if (cmd.div_step && it_reg != '0)
            it_reg <= it_reg - IT_W'(1);
    end

    ccsri_div u_div_a (
        .clk     (clk),
        .init    (cmd.div_init),
        .step    (cmd.div_step),
        .mag     (mag1_reg),
        .neg     (neg1_reg),
        .divisor (sum_reg),
        .value   (val_a),
        .sat     (sat_a)
    );

    ccsri_div u_div_b (
        .clk     (clk),
        .init    (cmd.div_init),
        .step    (cmd.div_step),
        .mag     (mag2_reg),
        .neg     (neg2_reg),
        .divisor (sum_reg),
        .value   (val_b),
        .sat     (sat_b)
    );

    // Result buffer: loaded only when empty, drained one beat at a time
    assign pop = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else if (cmd.load)
            cnt_reg <= pair_reg ? 2'd2 : 2'd1;
        else if (pop)
            cnt_reg <= cnt_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            slot0_reg <= '{row: r0_reg, col: c0_reg, value: val_a, sat: sat_a,
                           last: !pair_reg, eof: !pair_reg && eof_reg};
            slot1_reg <= '{row: r1_reg, col: c1_reg, value: val_b, sat: sat_b,
                           last: 1'b1, eof: eof_reg};
        end
        else if (pop)
            slot0_reg <= slot1_reg;
    end

    assign out_valid    = (cnt_reg != 2'd0);
    assign row_index    = slot0_reg.row;
    assign column_index = slot0_reg.col;
    assign result_value = slot0_reg.value;
    assign saturated    = slot0_reg.sat;
    assign last_of_run  = slot0_reg.last;
    assign end_of_frame = slot0_reg.eof;

    assign stat.kind     = kind;
    assign stat.div_last = (it_reg == '0);
    assign stat.buf_busy = (cnt_reg != 2'd0);

endmodule

FILE: src/ccsri_ctrl.sv
// ccsri_ctrl: sequencer for accept, squaring, division and result hand-off.
// Depends on ccsri_pkg.
module ccsri_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ccsri_pkg::stat_t  stat,
    output ccsri_pkg::cmd_t   cmd
);
    import ccsri_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid && stat.kind != KIND_HOLD)
                    state_next = ST_SQ1;
            end
            ST_SQ1:
            begin
                cmd.mul_en = 1'b1;
                state_next = ST_SQ2;
            end
            ST_SQ2:
            begin
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = 1'b1;
                cmd.sum_init = 1'b1;
                state_next   = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum_add  = 1'b1;
                cmd.div_init = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                    state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (!stat.buf_busy)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule

FILE: src/ccs_spectrum_regularized_inverse_top.sv
// Top level of the regularised inverse filter on a packed conjugate-symmetric spectrum.
// Depends on ccsri_pkg, ccsri_ctrl and ccsri_dp.
//
//  Channel  | Handshake             | Beat content
//  ---------+-----------------------+------------------------------------------------
//  in       | in_valid / in_ready   | spectrum_value
//  out      | out_valid / out_ready | row_index, column_index, result_value,
//           |                       | saturated, last_of_run, end_of_frame
//  cfg      | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// A beat that only holds a pair half is taken while the block stays idle. A beat
// that completes a pair or a real-only entry holds the input through the squaring,
// sum, division and load states, the division done by the two bit-serial dividers
// running side by side; both results of a pair come out of one run. Results sit in
// a two-deep buffer, so the next beat is taken while they wait; a new run stalls
// before loading until the buffer has fully drained. Reset clears state; no
// clearing pass is needed.
module ccs_spectrum_regularized_inverse_top #(
    parameter int MAX_DIM   = ccsri_pkg::MAX_DIM_DEF,
    parameter int FRAC_BITS = ccsri_pkg::FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [ccsri_pkg::VAL_W-1:0] spectrum_value,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [ccsri_pkg::POS_W-1:0]        row_index,
    output logic [ccsri_pkg::POS_W-1:0]        column_index,
    output logic signed [ccsri_pkg::VAL_W-1:0] result_value,
    output logic                               saturated,
    output logic                               last_of_run,
    output logic                               end_of_frame,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ccsri_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ccsri_pkg::VAL_W-1:0]        cfg_data
);
    import ccsri_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    ccsri_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ccsri_dp #(
        .MAX_DIM   (MAX_DIM),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .spectrum_value (spectrum_value),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .row_index      (row_index),
        .column_index   (column_index),
        .result_value   (result_value),
        .saturated      (saturated),
        .last_of_run    (last_of_run),
        .end_of_frame   (end_of_frame)
    );

endmodule

FILE: src/ccsri_chk.sv
// ccsri_chk: port-level checks on the result channel, bound to the top level.
// Depends on ccsri_pkg and ccs_spectrum_regularized_inverse_top.
module ccsri_chk (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic [ccsri_pkg::POS_W-1:0]        row_index,
    input logic [ccsri_pkg::POS_W-1:0]        column_index,
    input logic signed [ccsri_pkg::VAL_W-1:0] result_value,
    input logic                               saturated,
    input logic                               last_of_run,
    input logic                               end_of_frame
);
    import ccsri_pkg::*;

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_value)
            && $stable(row_index) && $stable(column_index))
        else $error("result beat changed while stalled");

    // End of frame only on the closing beat of a run
    a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && end_of_frame |-> last_of_run)
        else $error("end_of_frame without last_of_run");

    // A clipped value sits at one of the two limits
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |-> result_value == POS_LIMIT
            || result_value == NEG_LIMIT)
        else $error("saturated value not at a limit");

    // The second half of a pair is ready straight after the first
    a_pair_follow: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_of_run |=> out_valid && last_of_run)
        else $error("second result of a pair missing");

endmodule

bind ccs_spectrum_regularized_inverse_top ccsri_chk u_ccsri_chk (.*);

FILE: verif/tb_ccs_spectrum_regularized_inverse_top.sv
`timescale 1ns / 1ps
// Self-checking bench for the regularised inverse filter on a packed conjugate-symmetric spectrum.
// Depends on ccsri_pkg and ccs_spectrum_regularized_inverse_top; predicts every result beat
// in-bench and checks the output stream under random idling and long back-pressure.
module tb_ccs_spectrum_regularized_inverse_top;
    import ccsri_pkg::*;

    localparam int FRAC_BITS   = FRAC_BITS_DEF;
    localparam int IDLE_PCT    = 18;
    localparam int DRAIN_CYCLES = 100;
    localparam int LONG_STALL  = 1500;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int PHASES      = 15;
    localparam int PHASE_BEATS = 90;

    // Index with no register behind it; writes there are ignored
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct {
        logic [VAL_W-1:0] value;
        bit               wait_drain;
    } beat_t;

    logic                    clk;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic signed [VAL_W-1:0] spectrum_value = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic [POS_W-1:0]        row_index;
    logic [POS_W-1:0]        column_index;
    logic signed [VAL_W-1:0] result_value;
    logic                    saturated;
    logic                    last_of_run;
    logic                    end_of_frame;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [VAL_W-1:0]        cfg_data = '0;

    // Spectrum beats waiting to be offered, and result beats still owed by the block
    beat_t spectrum_beats [$];
    res_t  expected_inverses [$];

    // Shadow of the block's registers and state
    logic [VAL_W-1:0] gamma_reg  = GAMMA_RST;
    logic [DIM_W-1:0] width_reg  = DIM_RST;
    logic [DIM_W-1:0] height_reg = DIM_RST;
    logic [POS_W-1:0] row_cnt    = '0;
    logic [POS_W-1:0] col_cnt    = '0;
    logic [VAL_W-1:0] held_int   = '0;
    logic [VAL_W-1:0] held_first = '0;
    logic [VAL_W-1:0] held_last  = '0;

    int errors      = 0;
    int n_accepted  = 0;
    int hold_cycles = 0;
    int stalls_done = 0;
    int cycle_count = 0;

    // Directed sweep for a 4x4 frame with gamma zero, raster order
    logic [VAL_W-1:0] sweep [16] = '{
        32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h8000_0000,
        32'h7FFF_FFFF, 32'h0000_0001, 32'h8000_0000, 32'hFFFF_FFFF,
        32'h8000_0000, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_0001,
        32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF
    };

    // Frame sizes per random phase: extremes, out-of-range values, upper bits set
    logic [VAL_W-1:0] width_plan [PHASES] = '{
        32'd2, 32'd1024, 32'd7, 32'd0, 32'd6, 32'd1, 32'd2047, 32'hFFFF_F805,
        32'd4, 32'd3, 32'd8, 32'd16, 32'd2, 32'd9, 32'd10
    };
    logic [VAL_W-1:0] height_plan [PHASES] = '{
        32'd2, 32'd3, 32'd1024, 32'd5, 32'd1, 32'd4, 32'd6, 32'd0,
        32'd2047, 32'd7, 32'd2, 32'hFFFF_F808, 32'd12, 32'd3, 32'd1024
    };

    ccs_spectrum_regularized_inverse_top DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .spectrum_value (spectrum_value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .row_index      (row_index),
        .column_index   (column_index),
        .result_value   (result_value),
        .saturated      (saturated),
        .last_of_run    (last_of_run),
        .end_of_frame   (end_of_frame),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
        if (d < 2)
            return DIM_W'(2);
        if (d > MAX_DIM_DEF)
            return DIM_W'(MAX_DIM_DEF);
        return d;
    endfunction

    function automatic logic [VAL_W-1:0] magnitude_of(input logic [VAL_W-1:0] a);
        return a[VAL_W-1] ? -a : a;
    endfunction

    // Signed, saturated mag * 2^(2F) / denom, truncated toward zero
    function automatic logic [VAL_W-1:0] q_quotient(input logic [VAL_W-1:0] mag,
                                                    input bit neg,
                                                    input logic [SQ_W-1:0] denom,
                                                    output bit clip);
        logic [95:0]      num;
        logic [95:0]      quo;
        logic [VAL_W-1:0] lim;
        clip = 1'b0;
        if (denom == 0 || mag == 0)
            return '0;
        num = {64'b0, mag} << (2 * FRAC_BITS);
        quo = num / {32'b0, denom};
        lim = neg ? NEG_LIMIT : POS_LIMIT;
        if (quo > {64'b0, lim})
        begin
            clip = 1'b1;
            quo  = {64'b0, lim};
        end
        return neg ? -quo[VAL_W-1:0] : quo[VAL_W-1:0];
    endfunction

    function automatic res_t make_res(input logic [POS_W-1:0] r, input logic [POS_W-1:0] c,
                                      input logic [VAL_W-1:0] v, input bit clip);
        res_t e;
        e.row   = r;
        e.col   = c;
        e.value = v;
        e.sat   = clip;
        e.last  = 1'b0;
        e.eof   = 1'b0;
        return e;
    endfunction

    // Inverse of one accepted spectrum beat; queues its results and moves the raster position
    function automatic void predict_inverse(input logic [VAL_W-1:0] a);
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        logic [POS_W-1:0] r;
        logic [POS_W-1:0] c;
        logic [SQ_W-1:0]  g;
        logic [SQ_W-1:0]  s;
        logic [VAL_W-1:0] a1;
        logic [VAL_W-1:0] m1;
        logic [VAL_W-1:0] m2;
        logic [VAL_W-1:0] v;
        logic             vert;
        logic             right;
        bit               clip;
        res_t             batch [2];
        int               n;
        w = clamp_dim(width_reg);
        h = clamp_dim(height_reg);
        r = row_cnt;
        c = col_cnt;
        n = 0;
        g = {32'b0, gamma_reg} << FRAC_BITS;
        vert  = (c == 0) || (!w[0] && c == w - 1'b1);
        right = (c != 0);

        if (vert && (r == 0 || (!h[0] && r == h - 1'b1)))
        begin
            // real-only entry
            m1 = magnitude_of(a);
            v = q_quotient(m1, a[VAL_W-1], {32'b0, m1} * {32'b0, m1} + g, clip);
            batch[0] = make_res(r, c, v, clip);
            n = 1;
        end
        else if (vert && r[0])
        begin
            if (right)
                held_last = a;
            else
                held_first = a;
        end
        else if (!vert && c[0])
        begin
            held_int = a;
        end
        else
        begin
            // second half of a pair: both results, held half first
            a1 = !vert ? held_int : (right ? held_last : held_first);
            m1 = magnitude_of(a1);
            m2 = magnitude_of(a);
            s = {32'b0, m1} * {32'b0, m1} + {32'b0, m2} * {32'b0, m2} + g;
            v = q_quotient(m1, a1[VAL_W-1], s, clip);
            batch[0] = make_res(vert ? r - 1'b1 : r, vert ? c : c - 1'b1, v, clip);
            v = q_quotient(m2, !a[VAL_W-1], s, clip);
            batch[1] = make_res(r, c, v, clip);
            n = 2;
        end

        if (n > 0)
        begin
            batch[n-1].last = 1'b1;
            if (r == h - 1'b1 && c == w - 1'b1)
                batch[n-1].eof = 1'b1;
            for (int k = 0; k < n; k++)
                expected_inverses.push_back(batch[k]);
        end

        if (c + 1'b1 >= w)
        begin
            col_cnt = '0;
            row_cnt = (r + 1'b1 >= h) ? '0 : r + 1'b1;
        end
        else
        begin
            col_cnt = c + 1'b1;
        end
    endfunction

    // Random gap decision; a calm window mid-run has none on either side
    function automatic bit take_gap();
        if (n_accepted >= 550 && n_accepted < 750)
            return 1'b0;
        return $urandom_range(0, 99) < IDLE_PCT;
    endfunction

    task automatic check_field(input string name, input logic [VAL_W-1:0] want,
                               input logic [VAL_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    // Register write; only issued while the block is idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_GAMMA:
                gamma_reg = data;
            CFG_WIDTH:
            begin
                width_reg = data[DIM_W-1:0];
                row_cnt   = '0;
                col_cnt   = '0;
            end
            CFG_HEIGHT:
            begin
                height_reg = data[DIM_W-1:0];
                row_cnt    = '0;
                col_cnt    = '0;
            end
            default:
                ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (spectrum_beats.size() != 0 || in_valid || expected_inverses.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic queue_beat(input logic [VAL_W-1:0] v, input bit wait_drain);
        beat_t b;
        b.value      = v;
        b.wait_drain = wait_drain;
        spectrum_beats.push_back(b);
    endtask

    // Input driver: offers queued beats, predicts each one as it is taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid       <= 1'b0;
            spectrum_value <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_inverse(spectrum_value);
                spectrum_beats.delete(0);
                n_accepted++;
            end
            if (!in_valid || in_ready)
            begin
                if (spectrum_beats.size() != 0 && !take_gap() &&
                    !(spectrum_beats[0].wait_drain && expected_inverses.size() != 0))
                begin
                    in_valid       <= 1'b1;
                    spectrum_value <= spectrum_beats[0].value;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: checks each result beat, throttles ready, two long hold-offs
    always @(posedge clk or negedge rst_n)
    begin : result_side
        res_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_inverses.size() == 0)
                begin
                    $display("%0t: unexpected result beat, expected none, actual row %0d col %0d value %0h",
                             $time, row_index, column_index, result_value);
                    errors++;
                end
                else
                begin
                    want = expected_inverses.pop_front();
                    check_field("row_index", VAL_W'(want.row), VAL_W'(row_index));
                    check_field("column_index", VAL_W'(want.col), VAL_W'(column_index));
                    check_field("result_value", want.value, result_value);
                    check_field("saturated", VAL_W'(want.sat), VAL_W'(saturated));
                    check_field("last_of_run", VAL_W'(want.last), VAL_W'(last_of_run));
                    check_field("end_of_frame", VAL_W'(want.eof), VAL_W'(end_of_frame));
                end
            end
            if (hold_cycles != 0)
            begin
                hold_cycles--;
                out_ready <= 1'b0;
            end
            else if (stalls_done < 2 && n_accepted >= 400 + 600 * stalls_done)
            begin
                // sender keeps going meanwhile, so the block fills and stalls its input
                hold_cycles = LONG_STALL;
                stalls_done++;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= !take_gap();
            end
        end
    end

    // Run-away guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: cycle limit reached, %0d result beats outstanding",
                     $time, expected_inverses.size());
            $display("tb_ccs_spectrum_regularized_inverse_top: FAIL");
            $finish;
        end
    end

    // Stimulus sequence
    initial
    begin
        logic [VAL_W-1:0] v;
        logic [VAL_W-1:0] g;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // a few beats under reset configuration
        queue_beat(32'h0001_0000, 1'b0);
        queue_beat(32'h0000_8000, 1'b0);
        queue_beat(32'hFFFF_8000, 1'b0);
        queue_beat(32'h0002_0000, 1'b0);
        wait_idle();

        // full 4x4 frame, gamma zero: zero divisors, saturation, most negative value
        write_reg(CFG_GAMMA, 32'h0000_0000);
        write_reg(CFG_WIDTH, 32'd4);
        write_reg(CFG_HEIGHT, 32'd4);
        for (int i = 0; i < 16; i++)
            queue_beat(sweep[i], 1'b0);
        wait_idle();

        // smallest frame, largest gamma: every entry real-only
        write_reg(CFG_GAMMA, 32'hFFFF_FFFF);
        write_reg(CFG_WIDTH, 32'd2);
        write_reg(CFG_HEIGHT, 32'd2);
        queue_beat(32'h7FFF_FFFF, 1'b0);
        queue_beat(32'h8000_0000, 1'b0);
        queue_beat(32'h0000_0000, 1'b0);
        queue_beat(32'h0000_0001, 1'b0);

        // random phases, each under its own setting
        for (int p = 0; p < PHASES; p++)
        begin
            wait_idle();
            case (p % 5)
                0:       g = 32'h0000_0000;
                1:       g = 32'hFFFF_FFFF;
                2:       g = GAMMA_RST;
                3:       g = $urandom;
                default: g = $urandom_range(0, 32'h0000_4000);
            endcase
            if (p % 3 != 2)
                write_reg(CFG_GAMMA, g);
            write_reg(CFG_WIDTH, width_plan[p]);
            write_reg(CFG_HEIGHT, height_plan[p]);
            if (p == 4)
                write_reg(CFG_UNUSED, $urandom);
            for (int i = 0; i < PHASE_BEATS; i++)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2: v = $urandom;
                    3, 4, 5: v = $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
                    6, 7:    v = $urandom_range(0, 32'h0000_3FFF) - 32'h0000_2000;
                    8:       v = $urandom_range(0, 255);
                    default:
                    begin
                        case ($urandom_range(0, 4))
                            0:       v = 32'h0000_0000;
                            1:       v = 32'hFFFF_FFFF;
                            2:       v = 32'h7FFF_FFFF;
                            3:       v = 32'h8000_0000;
                            default: v = 32'h0000_0001;
                        endcase
                    end
                endcase
                // occasionally hold the next beat back until the output has caught up
                queue_beat(v, i == 45 || $urandom_range(0, 59) == 0);
            end
        end

        wait_idle();
        if (errors == 0)
            $display("tb_ccs_spectrum_regularized_inverse_top: PASS");
        else
            $display("tb_ccs_spectrum_regularized_inverse_top: FAIL");
        $finish;
    end

endmodule

FILE: files.f
src/ccsri_pkg.sv
src/ccsri_div.sv
src/ccsri_dp.sv
src/ccsri_ctrl.sv
src/ccs_spectrum_regularized_inverse_top.sv
src/ccsri_chk.sv
verif/tb_ccs_spectrum_regularized_inverse_top.sv
